@@ src/refcounted_inode_cache_assert.svh @@
// Assertion macros for the inode cache checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef REFCOUNTED_INODE_CACHE_ASSERT_SVH
`define REFCOUNTED_INODE_CACHE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RIC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ric_checker: same-cycle property failed");

// Consequent must hold in the cycle after the antecedent.
`define RIC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ric_checker: next-cycle property failed");

`endif

@@ src/ric_pkg.sv @@
// Shared types and constants of the reference-counted inode cache.
// Used by the slot unit, the top level and the checker; depends on nothing.
package ric_pkg;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 88;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // Operation codes carried in the input tuser.
    localparam logic [1:0] OP_ACQUIRE = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_MARK    = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    // Result status codes carried in the output tuser.
    localparam logic [2:0] ST_HIT       = 3'd0;
    localparam logic [2:0] ST_ALLOC     = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_STILL_REF = 3'd3;
    localparam logic [2:0] ST_CLEAN     = 3'd4;
    localparam logic [2:0] ST_WRITEBACK = 3'd5;
    localparam logic [2:0] ST_MARKED    = 3'd6;
    localparam logic [2:0] ST_ERROR     = 3'd7;

    // One slot of the cache as it is held in the slot RAM.
    typedef struct packed {
        logic [7:0]  dev;
        logic [31:0] ino;
        logic [15:0] cnt;
        logic        dirty;
    } entry_t;

    // What the slot unit reports about the entry it was given.
    typedef struct packed {
        logic        match;
        logic        free;
        logic [2:0]  status;
        logic        wr_en;
        entry_t      wr_entry;
    } slot_res_t;

endpackage

@@ src/refcounted_inode_cache.sv @@
// Top level of the reference-counted inode cache: sequencer, valid bits, config.
// Depends on ric_pkg, ric_ram and ric_slot_unit.
//
// This block keeps SLOT_COUNT cached inode slots, each with a device and inode
// tag, a 16-bit reference count and a dirty mark, all held in one slot RAM and
// visited one slot per cycle by a shared compare and count unit. The opcode
// travels in s_tuser and the status in m_tuser. An acquire scans the slots
// from slot 0: it stops at the first tag match (stale slots with a zero count
// match too) and otherwise claims the lowest slot with a zero count, so a hit
// at slot k ends the scan there, while a miss or a full table visits every
// slot through the RAM read port. Release and mark-dirty read their one slot,
// a release or mark with a slot index beyond the table reads no slot and
// reports an error, and the unused opcode gives no result word. Each
// accepted word other than the unused opcode gives exactly one result word. A
// finished result waits in the output register, and the next input word is
// accepted while it waits. Per-slot valid bits make every slot read as all
// zero after reset, so no clearing pass is needed. The inode table start
// register is written through the cfg channel, which is always ready, and
// should only be written while no operation is in flight.
module refcounted_inode_cache
    import ric_pkg::*;
#(
    parameter int SLOT_COUNT = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration write channel: inode_table_start.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [31:0]            cfg_data,
    // Input stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // s_tdata, lowest bit up: device_id[7:0], inode_number[39:8],
    // slot_index[45:40], zero fill[47:46].
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // s_tuser: opcode[1:0].
    input  logic [1:0]             s_tuser,
    // Output stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // m_tdata, lowest bit up: slot_out[5:0], device_out[13:6],
    // inode_out[45:14], disk_block[77:46], block_offset[80:78],
    // zero fill[87:81].
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // m_tuser: status[2:0].
    output logic [2:0]             m_tuser
);

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int ENTRY_W = $bits(entry_t);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
    localparam logic [8:0] SLOT_LIMIT = 9'(SLOT_COUNT);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LOOK,
        S_RESP
    } state_t;

    state_t                  state_reg, state_next;
    logic [1:0]              op_reg, op_next;
    logic [7:0]              dev_reg, dev_next;
    logic [31:0]             ino_reg, ino_next;
    logic [IDX_W-1:0]        slot_reg, slot_next;
    logic [IDX_W-1:0]        cur_reg, cur_next;
    logic                    free_found_reg, free_found_next;
    logic [IDX_W-1:0]        free_idx_reg, free_idx_next;
    logic [2:0]              res_status_reg, res_status_next;
    logic [5:0]              res_slot_reg, res_slot_next;
    logic [7:0]              res_dev_reg, res_dev_next;
    logic [31:0]             res_ino_reg, res_ino_next;
    logic                    res_desc_reg, res_desc_next;
    logic [31:0]             start_reg, start_next;
    logic [SLOT_COUNT-1:0]   valid_reg, valid_next;
    logic                    rd_valid_reg, rd_valid_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [2:0]              m_tuser_reg, m_tuser_next;

    logic                    accept;
    logic [1:0]              in_op;
    logic [7:0]              in_dev;
    logic [31:0]             in_ino;
    logic [5:0]              in_slot;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    entry_t                  ram_wdata;
    logic [IDX_W-1:0]        rd_addr;
    logic [ENTRY_W-1:0]      ram_q;
    entry_t                  entry_q;
    slot_res_t               unit_res;

    logic [31:0]             rel_ino;
    logic [31:0]             blk;
    logic [2:0]              offset;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;

    assign in_op   = s_tuser;
    assign in_dev  = s_tdata[7:0];
    assign in_ino  = s_tdata[39:8];
    assign in_slot = s_tdata[45:40];

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // A slot that was never written reads as all zero.
    assign entry_q = rd_valid_reg ? entry_t'(ram_q) : '0;

    ric_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    ric_slot_unit u_slot_unit (
        .op      (op_reg),
        .req_dev (dev_reg),
        .req_ino (ino_reg),
        .entry   (entry_q),
        .res     (unit_res)
    );

    // Block address and offset of the reported inode, formed as the result
    // moves into the output register.
    assign rel_ino = res_ino_reg - 32'd1;
    assign blk     = res_desc_reg ? ({3'b000, rel_ino[31:3]} + start_reg) : 32'd0;
    assign offset  = res_desc_reg ? rel_ino[2:0] : 3'd0;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        dev_next        = dev_reg;
        ino_next        = ino_reg;
        slot_next       = slot_reg;
        cur_next        = cur_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_dev_next    = res_dev_reg;
        res_ino_next    = res_ino_reg;
        res_desc_next   = res_desc_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        ram_we          = 1'b0;
        ram_waddr       = cur_reg;
        ram_wdata       = unit_res.wr_entry;
        rd_addr         = '0;

        start_next = cfg_valid ? cfg_data : start_reg;

        // The waiting result leaves when the consumer takes it.
        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = in_op;
                    dev_next = in_dev;
                    ino_next = in_ino;
                    case (in_op)
                        OP_ACQUIRE:
                        begin
                            rd_addr         = '0;
                            cur_next        = '0;
                            free_found_next = 1'b0;
                            state_next      = S_SCAN;
                        end
                        OP_RELEASE, OP_MARK:
                        begin
                            if ({3'b000, in_slot} >= SLOT_LIMIT)
                            begin
                                // Slot beyond the table: report an error only.
                                res_status_next = ST_ERROR;
                                res_slot_next   = in_slot;
                                res_dev_next    = 8'd0;
                                res_ino_next    = 32'd0;
                                res_desc_next   = 1'b0;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                rd_addr    = IDX_W'(in_slot);
                                slot_next  = IDX_W'(in_slot);
                                state_next = S_LOOK;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // The data of slot cur_reg is on the RAM output; fetch the next.
                rd_addr  = (cur_reg == LAST_IDX) ? '0 : cur_reg + 1'b1;
                cur_next = cur_reg + 1'b1;
                if (unit_res.match)
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = cur_reg;
                    ram_wdata       = unit_res.wr_entry;
                    res_status_next = ST_HIT;
                    res_slot_next   = 6'(cur_reg);
                    res_dev_next    = entry_q.dev;
                    res_ino_next    = entry_q.ino;
                    res_desc_next   = 1'b1;
                    state_next      = S_RESP;
                end
                else
                begin
                    if (unit_res.free && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = cur_reg;
                    end
                    if (cur_reg == LAST_IDX)
                    begin
                        state_next = S_RESP;
                        if (free_found_reg || unit_res.free)
                        begin
                            ram_we          = 1'b1;
                            ram_waddr       = free_found_reg ? free_idx_reg : cur_reg;
                            ram_wdata.dev   = dev_reg;
                            ram_wdata.ino   = ino_reg;
                            ram_wdata.cnt   = 16'd1;
                            ram_wdata.dirty = 1'b0;
                            res_status_next = ST_ALLOC;
                            res_slot_next   = 6'(ram_waddr);
                            res_dev_next    = dev_reg;
                            res_ino_next    = ino_reg;
                            res_desc_next   = 1'b1;
                        end
                        else
                        begin
                            res_status_next = ST_FULL;
                            res_slot_next   = 6'd0;
                            res_dev_next    = 8'd0;
                            res_ino_next    = 32'd0;
                            res_desc_next   = 1'b0;
                        end
                    end
                end
            end
            S_LOOK:
            begin
                ram_we          = unit_res.wr_en;
                ram_waddr       = slot_reg;
                ram_wdata       = unit_res.wr_entry;
                res_status_next = unit_res.status;
                res_slot_next   = 6'(slot_reg);
                res_dev_next    = entry_q.dev;
                res_ino_next    = entry_q.ino;
                res_desc_next   = 1'b1;
                state_next      = S_RESP;
            end
            S_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'd0, offset, blk, res_ino_reg, res_dev_reg,
                                     res_slot_reg};
                    m_tuser_next  = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        valid_next = valid_reg;
        if (ram_we)
        begin
            valid_next = valid_reg | ({{(SLOT_COUNT - 1){1'b0}}, 1'b1} << ram_waddr);
        end
        rd_valid_next = valid_reg[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_NONE;
            dev_reg        <= '0;
            ino_reg        <= '0;
            slot_reg       <= '0;
            cur_reg        <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            res_status_reg <= ST_HIT;
            res_slot_reg   <= '0;
            res_dev_reg    <= '0;
            res_ino_reg    <= '0;
            res_desc_reg   <= 1'b0;
            start_reg      <= '0;
            valid_reg      <= '0;
            rd_valid_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            m_tuser_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            dev_reg        <= dev_next;
            ino_reg        <= ino_next;
            slot_reg       <= slot_next;
            cur_reg        <= cur_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            res_status_reg <= res_status_next;
            res_slot_reg   <= res_slot_next;
            res_dev_reg    <= res_dev_next;
            res_ino_reg    <= res_ino_next;
            res_desc_reg   <= res_desc_next;
            start_reg      <= start_next;
            valid_reg      <= valid_next;
            rd_valid_reg   <= rd_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
            m_tdata_reg    <= m_tdata_next;
            m_tuser_reg    <= m_tuser_next;
        end
    end

endmodule

@@ src/ric_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ric_ram #(
    parameter int WIDTH = 57,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/ric_slot_unit.sv @@
// Shared tag compare and count update unit, applied to one slot per cycle.
// Depends on ric_pkg.
module ric_slot_unit
    import ric_pkg::*;
(
    input  logic [1:0]  op,
    input  logic [7:0]  req_dev,
    input  logic [31:0] req_ino,
    input  entry_t      entry,
    output slot_res_t   res
);

    logic        is_acq;
    logic        hold;
    logic [15:0] addend;
    logic [15:0] cnt_next;

    // One adder serves both increment and decrement; the count saturates at
    // the top on acquire and stays at zero on release.
    assign is_acq   = (op == OP_ACQUIRE);
    assign addend   = is_acq ? 16'h0001 : 16'hFFFF;
    assign hold     = is_acq ? (entry.cnt == COUNT_MAX) : (entry.cnt == 16'd0);
    assign cnt_next = hold ? entry.cnt : entry.cnt + addend;

    always_comb
    begin
        res          = '0;
        res.match    = is_acq && (req_ino != 32'd0) && (entry.dev == req_dev)
                       && (entry.ino == req_ino);
        res.free     = (entry.cnt == 16'd0);
        res.wr_entry = entry;
        case (op)
            OP_ACQUIRE:
            begin
                res.status       = ST_HIT;
                res.wr_en        = res.match;
                res.wr_entry.cnt = cnt_next;
            end
            OP_MARK:
            begin
                res.status         = ST_MARKED;
                res.wr_en          = 1'b1;
                res.wr_entry.dirty = 1'b1;
            end
            OP_RELEASE:
            begin
                res.wr_entry.cnt = cnt_next;
                if (entry.cnt == 16'd0)
                begin
                    res.status = ST_ERROR;
                    res.wr_en  = 1'b0;
                end
                else if (cnt_next != 16'd0)
                begin
                    res.status = ST_STILL_REF;
                    res.wr_en  = 1'b1;
                end
                else if (entry.dirty)
                begin
                    res.status         = ST_WRITEBACK;
                    res.wr_en          = 1'b1;
                    res.wr_entry.dirty = 1'b0;
                end
                else
                begin
                    res.status = ST_CLEAN;
                    res.wr_en  = 1'b1;
                end
            end
            default:
            begin
                res.status = ST_ERROR;
                res.wr_en  = 1'b0;
            end
        endcase
    end

endmodule

@@ src/ric_checker.sv @@
// Port-level assertions for the inode cache, bound to the top level.
// Depends on ric_pkg and refcounted_inode_cache_assert.svh.
`include "refcounted_inode_cache_assert.svh"

module ric_checker
    import ric_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   cfg_valid,
    input logic                   cfg_ready,
    input logic [31:0]            cfg_data,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [IN_TDATA_W-1:0]  s_tdata,
    input logic [1:0]             s_tuser,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic [2:0]             m_tuser
);

    // A stalled result word keeps its value.
    `RIC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // A real operation keeps the block busy for at least the next cycle.
    `RIC_ASSERT_NEXT(a_busy_after_op, s_tvalid && s_tready && (s_tuser != OP_NONE), !s_tready)

    // A full table reports no slot data at all.
    `RIC_ASSERT_SAME(a_full_zero, m_tvalid && (m_tuser == ST_FULL), m_tdata == '0)

    // A described slot gives the offset of its inode within the block.
    `RIC_ASSERT_SAME(a_offset, m_tvalid && (m_tuser != ST_FULL) && (m_tuser != ST_ERROR), m_tdata[80:78] == (m_tdata[16:14] - 3'd1))

endmodule

bind refcounted_inode_cache ric_checker u_ric_checker (.*);
